// ----- hw/rtl/ostt_pkg.sv -----
// Package for the one-shot timer table: slot count, operation and reply codes,
// and the item token and expiry structs passed along the cell chain.
// No dependencies.
package ostt_pkg;

  localparam int SLOTS = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_CHECK  = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  // item moving down the chain; flag is taken / found / passed
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [7:0]  owner;
    logic [31:0] deadline;
    logic        flag;
  } token_t;

  // expiry raised by one cell
  typedef struct packed {
    logic        hit;
    logic [7:0]  owner;
    logic [31:0] deadline;
  } expiry_t;

endpackage

// ----- hw/rtl/one_shot_timer_table_top.sv -----
// Top level of the one-shot timer table: tick counter, launch register,
// chain of ostt_cell slots, expiry holding register and result registers.
// Depends on ostt_pkg and ostt_cell.

// An item is taken when start is high and busy is low; busy then stays high
// while the item walks the chain of SLOTS cells, one cell per clock, so the next
// item is taken only once the current one has left the chain and busy is low.
// Start, stop and check give one result, strobed by done in the cycle busy
// falls. A tick gives one expiry result per freed slot, in slot order, each
// on done for a single cycle with the final one marked by last; a tick that
// frees nothing gives no result. Results cannot be held off by the receiver.
module one_shot_timer_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [31:0] wait_ticks,
  input  logic [7:0]         owner,
  input  logic signed [31:0] query_deadline,
  output logic               done,
  output logic [1:0]         kind,
  output logic [7:0]         expired_owner,
  output logic signed [31:0] deadline_out,
  output logic               flag,
  output logic               last
);

  localparam int N = ostt_pkg::SLOTS;

  ostt_pkg::token_t  tok [N+1];
  ostt_pkg::expiry_t expiry [N];
  ostt_pkg::token_t  launch;
  ostt_pkg::token_t  launch_next;
  ostt_pkg::expiry_t exp_any;

  logic [31:0] tick_count;
  logic [31:0] wait_clamped;
  logic [31:0] check_diff;
  logic [N:0]  tok_valid;
  logic        accept;

  logic        pend_valid;
  logic        pend_valid_next;
  logic [7:0]  pend_owner;
  logic [31:0] pend_deadline;
  logic        pend_load;

  logic        out_load;
  logic [1:0]  kind_next;
  logic [7:0]  owner_next;
  logic [31:0] deadline_next;
  logic        flag_next;
  logic        last_next;

  assign accept       = start && !busy;
  assign wait_clamped = wait_ticks[31] ? 32'd0 : wait_ticks;
  assign check_diff   = tick_count - query_deadline;

  always_comb begin
    for (int k = 0; k <= N; k++) begin
      tok_valid[k] = tok[k].valid;
    end
  end
  assign busy = |tok_valid;

  always_comb begin
    launch_next          = '0;
    launch_next.valid    = 1'b1;
    launch_next.op       = ostt_pkg::op_t'(op);
    launch_next.owner    = owner;
    launch_next.deadline = tick_count + wait_clamped;
    launch_next.flag     = (ostt_pkg::op_t'(op) == ostt_pkg::OP_CHECK) && !check_diff[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 32'd0;
      launch.valid <= 1'b0;
    end else begin
      if (accept) begin
        launch <= launch_next;
        if (ostt_pkg::op_t'(op) == ostt_pkg::OP_TICK) begin
          tick_count <= tick_count + 32'd1;
        end
      end else begin
        launch.valid <= 1'b0;
      end
    end
  end

  assign tok[0] = launch;

  for (genvar g = 0; g < N; g++) begin : g_cell
    ostt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tick_count (tick_count),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1]),
      .expiry     (expiry[g])
    );
  end

  always_comb begin
    exp_any = '0;
    for (int k = 0; k < N; k++) begin
      exp_any = exp_any | expiry[k];
    end
  end

  // an expiry is held until the next one or the end of the chain decides last
  always_comb begin
    out_load        = 1'b0;
    kind_next       = ostt_pkg::KIND_EXPIRY;
    owner_next      = pend_owner;
    deadline_next   = pend_deadline;
    flag_next       = 1'b0;
    last_next       = 1'b0;
    pend_valid_next = pend_valid;
    pend_load       = 1'b0;
    if (tok[N].valid) begin
      case (tok[N].op)
        ostt_pkg::OP_TICK: begin
          out_load        = pend_valid;
          last_next       = 1'b1;
          pend_valid_next = 1'b0;
        end
        ostt_pkg::OP_START: begin
          out_load      = 1'b1;
          kind_next     = ostt_pkg::KIND_START;
          owner_next    = 8'd0;
          deadline_next = tok[N].deadline;
          flag_next     = tok[N].flag;
        end
        ostt_pkg::OP_STOP: begin
          out_load      = 1'b1;
          kind_next     = ostt_pkg::KIND_STOP;
          owner_next    = 8'd0;
          deadline_next = 32'd0;
          flag_next     = tok[N].flag;
        end
        default: begin
          out_load      = 1'b1;
          kind_next     = ostt_pkg::KIND_CHECK;
          owner_next    = 8'd0;
          deadline_next = 32'd0;
          flag_next     = tok[N].flag;
        end
      endcase
    end else if (exp_any.hit) begin
      out_load        = pend_valid;
      pend_valid_next = 1'b1;
      pend_load       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
      done       <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_owner    <= exp_any.owner;
      pend_deadline <= exp_any.deadline;
    end
    if (out_load) begin
      kind          <= kind_next;
      expired_owner <= owner_next;
      deadline_out  <= deadline_next;
      flag          <= flag_next;
      last          <= last_next;
    end
  end

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one item in the chain");

  a_reply_follows: assert property (@(posedge clk) disable iff (rst)
    (tok[N].valid && tok[N].op != ostt_pkg::OP_TICK) |=> done)
    else $error("reply missing at end of chain");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy low after accept");

  a_last_is_expiry: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> (kind == ostt_pkg::KIND_EXPIRY))
    else $error("last set on a non-expiry result");
`endif

endmodule

// ----- hw/rtl/ostt_cell.sv -----
// One timer slot of the chain: owner handle and deadline, acting on the item
// token as it passes and handing the token to the next cell.
// Depends on ostt_pkg.
module ostt_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           tick_count,
  input  ostt_pkg::token_t      tok_in,
  output ostt_pkg::token_t      tok_out,
  output ostt_pkg::expiry_t     expiry
);

  logic [7:0]       slot_owner;
  logic [7:0]       slot_owner_next;
  logic [31:0]      slot_deadline;
  logic             deadline_write;
  logic [31:0]      diff;
  ostt_pkg::token_t tok_next;

  assign diff = tick_count - slot_deadline;

  always_comb begin
    tok_next        = tok_in;
    slot_owner_next = slot_owner;
    deadline_write  = 1'b0;
    expiry          = '0;
    if (tok_in.valid) begin
      case (tok_in.op)
        ostt_pkg::OP_TICK: begin
          if (slot_owner != 8'd0 && !diff[31]) begin
            expiry.hit      = 1'b1;
            expiry.owner    = slot_owner;
            expiry.deadline = slot_deadline;
            slot_owner_next = 8'd0;
          end
        end
        ostt_pkg::OP_START: begin
          if (tok_in.owner != 8'd0 && !tok_in.flag && slot_owner == 8'd0) begin
            slot_owner_next = tok_in.owner;
            deadline_write  = 1'b1;
            tok_next.flag   = 1'b1;
          end
        end
        ostt_pkg::OP_STOP: begin
          if (tok_in.owner != 8'd0 && !tok_in.flag && slot_owner == tok_in.owner) begin
            slot_owner_next = 8'd0;
            tok_next.flag   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_owner    <= 8'd0;
      tok_out.valid <= 1'b0;
    end else begin
      slot_owner <= slot_owner_next;
      tok_out    <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (deadline_write) begin
      slot_deadline <= tok_in.deadline;
    end
  end

endmodule
